// ===== sv/assert_macros.svh =====
// Assertion helpers used by the RTL file binned_block_allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A trigger implies a consequence on the next edge.
`define ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/bba_pkg.sv =====
package bba_pkg;
    localparam int PAGE_BYTES = 4096;
    localparam int PAGE_COUNT = 64;
    localparam int BIN_COUNT = 8;
    localparam int HEADER_BYTES = 64;
    localparam int MAX_ALIGN = 16;
    localparam int MIN_BLOCK = 16;
    localparam int SLOTS_PER_PAGE = PAGE_BYTES / MIN_BLOCK;
    localparam int SLOT_TOTAL = PAGE_COUNT * SLOTS_PER_PAGE;
    localparam int SLOT_W = $clog2(SLOT_TOTAL + 1);
    localparam int IDX_W = $clog2(SLOT_TOTAL);
    localparam int SOFF_W = $clog2(SLOTS_PER_PAGE);
    localparam int PAGE_W = $clog2(PAGE_COUNT);
    localparam int PCNT_W = $clog2(PAGE_COUNT + 1);
    localparam int BIN_W = 3;
    localparam int BIDX_W = $clog2(BIN_COUNT);
    localparam int POFF_W = $clog2(PAGE_BYTES);
    localparam logic [SLOT_W-1:0] NULL_SLOT = SLOT_W'(SLOT_TOTAL);
    localparam int HDR_SLOTS = HEADER_BYTES / MIN_BLOCK;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NO_PAGE = 2'd1;
    localparam logic [1:0] ST_TOO_BIG = 2'd2;
    localparam logic [1:0] ST_BAD_FREE = 2'd3;

    localparam logic REG_BASE = 1'b0;
    localparam logic REG_LIMIT = 1'b1;

    // Number of blocks of a bin that fit after the page header.
    function automatic logic [SOFF_W:0] blocks_per_page(input logic [BIDX_W-1:0] b);
        return (SOFF_W + 1)'(((PAGE_BYTES - HEADER_BYTES) / MIN_BLOCK) >> b);
    endfunction
endpackage

// ===== sv/binned_block_allocator.sv =====
// Binned block allocator: a segregated free-list allocator over a region of
// pages. Requests enter on start with kind (0 allocate, 1 free), size,
// alignment and addr, and are taken when start is high and busy is low.
// Each request returns one result on status, block_addr and bin, marked by
// done for a single cycle; the receiver cannot stall, so results are never
// held. Configuration is written through cfg_we, cfg_index and cfg_wdata
// (0 region_base, 1 page_limit); the user must write it only while the block
// is idle, which the block itself does not enforce. An allocate from a
// non-empty bin passes decode, link memory read, writeback and result; a
// free passes decode with the page bin read, check and push, and result. An
// allocate that claims a new page first carves its blocks one after another,
// up to 252, as every block link is written through the single link memory
// port. busy is high from transfer to done, so one request is in flight at a
// time.
// Reset empties all bin lists and the page count; the link and page bin
// memories are not cleared, since an entry is read only after it is written.
module binned_block_allocator (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  logic         kind,
    input  logic [31:0]  size,
    input  logic [31:0]  alignment,
    input  logic [47:0]  addr,
    output logic         done,
    output logic [1:0]   status,
    output logic [47:0]  block_addr,
    output logic [2:0]   bin,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [47:0]  cfg_wdata
);
`include "assert_macros.svh"

    localparam int SW = bba_pkg::SLOT_W;
    localparam int IW = bba_pkg::IDX_W;
    localparam int BW = bba_pkg::BIDX_W;
    localparam int PW = bba_pkg::PAGE_W;
    localparam int OW = bba_pkg::SOFF_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CARVE = 3'd1;
    localparam logic [2:0] S_POP   = 3'd2;
    localparam logic [2:0] S_POPWB = 3'd3;
    localparam logic [2:0] S_FREE  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] state_reg;
    logic [47:0] base_reg;
    logic [6:0] limit_reg;
    logic [SW-1:0] head_reg [bba_pkg::BIN_COUNT];
    logic [bba_pkg::PCNT_W-1:0] used_reg;

    logic [BW-1:0] b_reg;
    logic [SW-1:0] slot_reg;
    logic [OW:0] cnt_reg;
    logic [PW-1:0] page_reg;
    logic [bba_pkg::POFF_W-1:0] inpage_reg;
    logic [1:0] status_reg;
    logic [47:0] addr_out_reg;
    logic [2:0] bin_reg;
    logic done_reg;

    // Link memory and page bin memory.
    logic link_we;
    logic [IW-1:0] link_waddr, link_raddr;
    logic [SW-1:0] link_wdata, link_rdata;
    logic pb_we;
    logic [PW-1:0] pb_addr;
    logic [BW-1:0] pb_rdata;

    bba_ram #(.WIDTH(SW), .DEPTH(bba_pkg::SLOT_TOTAL)) u_link (
        .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
        .raddr(link_raddr), .rdata(link_rdata)
    );

    bba_ram #(.WIDTH(BW), .DEPTH(bba_pkg::PAGE_COUNT)) u_page_bin (
        .clk(clk), .we(pb_we), .waddr(pb_addr), .wdata(b_reg),
        .raddr(pb_addr), .rdata(pb_rdata)
    );

    // Request decode.
    logic [31:0] size_m1;
    logic [BW:0] req_bin;
    logic size_big;
    always_comb
    begin
        size_m1 = (size == 32'd0) ? 32'd0 : size - 32'd1;
        req_bin = '0;
        size_big = 1'b1;
        for (int i = bba_pkg::BIN_COUNT - 1; i >= 0; i--)
        begin
            if ((size_m1 >> 4) < (32'd1 << i))
            begin
                req_bin = (BW + 1)'(i);
                size_big = 1'b0;
            end
        end
    end

    logic [47:0] rel_off;
    assign rel_off = addr - base_reg;

    logic accept;
    assign accept = start && !busy;

    logic [PW:0] eff_limit;
    assign eff_limit = (limit_reg > 7'(bba_pkg::PAGE_COUNT)) ?
        (PW + 1)'(bba_pkg::PAGE_COUNT) : (PW + 1)'(limit_reg);

    // Free address check against the page's bin.
    logic [bba_pkg::POFF_W-1:0] rel_in;
    logic [bba_pkg::POFF_W-1:0] bsz_mask;
    logic [OW:0] free_idx;
    logic free_ok;
    always_comb
    begin
        rel_in = inpage_reg - bba_pkg::POFF_W'(bba_pkg::HEADER_BYTES);
        bsz_mask = bba_pkg::POFF_W'((bba_pkg::MIN_BLOCK << pb_rdata) - 1);
        free_idx = (OW + 1)'(rel_in >> (4 + pb_rdata));
        free_ok = (inpage_reg >= bba_pkg::POFF_W'(bba_pkg::HEADER_BYTES))
            && ((rel_in & bsz_mask) == '0)
            && (free_idx < bba_pkg::blocks_per_page(pb_rdata));
    end

    // Carve: slot of block cnt_reg in page used_reg.
    logic [SW-1:0] carve_slot;
    assign carve_slot = SW'({used_reg[PW-1:0], OW'(0)})
        + SW'(bba_pkg::HDR_SLOTS) + SW'(SW'(cnt_reg) << b_reg);

    always_comb
    begin
        link_we = 1'b0;
        link_waddr = slot_reg[IW-1:0];
        link_wdata = head_reg[b_reg];
        link_raddr = slot_reg[IW-1:0];
        pb_we = 1'b0;
        pb_addr = page_reg;
        if (state_reg == S_IDLE)
        begin
            // The page bin is read at the transfer edge, ready for the check.
            pb_addr = rel_off[bba_pkg::POFF_W +: PW];
        end
        else if (state_reg == S_CARVE)
        begin
            link_we = 1'b1;
            link_waddr = carve_slot[IW-1:0];
            pb_we = (cnt_reg == '0);
            pb_addr = used_reg[PW-1:0];
        end
        else if (state_reg == S_FREE && free_ok)
        begin
            link_we = 1'b1;
            link_waddr = IW'({page_reg, inpage_reg[bba_pkg::POFF_W-1:4]});
            link_wdata = head_reg[pb_rdata];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            base_reg <= '0;
            limit_reg <= 7'd64;
            used_reg <= '0;
            done_reg <= 1'b0;
            for (int i = 0; i < bba_pkg::BIN_COUNT; i++)
            begin
                head_reg[i] <= bba_pkg::NULL_SLOT;
            end
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_we)
            begin
                if (cfg_index == bba_pkg::REG_BASE)
                begin
                    base_reg <= cfg_wdata;
                end
                else
                begin
                    limit_reg <= cfg_wdata[6:0];
                end
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        status_reg <= bba_pkg::ST_OK;
                        addr_out_reg <= '0;
                        bin_reg <= '0;
                        state_reg <= S_DONE;
                        if (!kind)
                        begin
                            if (alignment > 32'(bba_pkg::MAX_ALIGN) || size_big ||
                                bba_pkg::blocks_per_page(req_bin[BW-1:0]) == '0)
                            begin
                                status_reg <= bba_pkg::ST_TOO_BIG;
                            end
                            else
                            begin
                                b_reg <= req_bin[BW-1:0];
                                bin_reg <= 3'(req_bin);
                                slot_reg <= head_reg[req_bin[BW-1:0]];
                                cnt_reg <= '0;
                                if (head_reg[req_bin[BW-1:0]] != bba_pkg::NULL_SLOT)
                                begin
                                    state_reg <= S_POP;
                                end
                                else if ((PW + 1)'(used_reg) >= eff_limit)
                                begin
                                    status_reg <= bba_pkg::ST_NO_PAGE;
                                end
                                else
                                begin
                                    state_reg <= S_CARVE;
                                end
                            end
                        end
                        else if (addr != '0)
                        begin
                            if (rel_off >= 48'(used_reg) * 48'(bba_pkg::PAGE_BYTES))
                            begin
                                status_reg <= bba_pkg::ST_BAD_FREE;
                            end
                            else
                            begin
                                page_reg <= rel_off[bba_pkg::POFF_W +: PW];
                                inpage_reg <= rel_off[bba_pkg::POFF_W-1:0];
                                state_reg <= S_FREE;
                            end
                        end
                    end
                end
                S_CARVE:
                begin
                    head_reg[b_reg] <= carve_slot;
                    slot_reg <= carve_slot;
                    if (cnt_reg == bba_pkg::blocks_per_page(b_reg) - 1'b1)
                    begin
                        used_reg <= used_reg + 1'b1;
                        state_reg <= S_POP;
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                end
                S_POP:
                begin
                    state_reg <= S_POPWB;
                end
                S_POPWB:
                begin
                    head_reg[b_reg] <= link_rdata;
                    addr_out_reg <= base_reg + 48'({slot_reg[IW-1:0], 4'b0000});
                    state_reg <= S_DONE;
                end
                S_FREE:
                begin
                    if (free_ok)
                    begin
                        slot_reg <= SW'({page_reg, inpage_reg[bba_pkg::POFF_W-1:4]});
                        head_reg[pb_rdata] <= SW'({page_reg, inpage_reg[bba_pkg::POFF_W-1:4]});
                        bin_reg <= 3'(pb_rdata);
                    end
                    else
                    begin
                        status_reg <= bba_pkg::ST_BAD_FREE;
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    done_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy = (state_reg != S_IDLE) || done_reg;
    assign done = done_reg;
    assign status = status_reg;
    assign block_addr = addr_out_reg;
    assign bin = bin_reg;

    `ASSERT_CLK(a_done_busy, !done || busy, "result shown while idle")
    `ASSERT_NEXT(a_accept_busy, accept, busy, "request taken without going busy")
    `ASSERT_CLK(a_used_bound, used_reg <= bba_pkg::PCNT_W'(bba_pkg::PAGE_COUNT),
        "page count overran the region")
    `ASSERT_CLK(a_fail_zero, !done || status == bba_pkg::ST_OK || block_addr == '0,
        "failed request returned an address")
endmodule

// ===== sv/bba_ram.sv =====
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
